@@ hdl/cylinder_vertex_generator_macros.svh @@
// ----------------------------------------------------------------------------
// cylinder vertex generator assertion macros
// shared property wrappers, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef CYLINDER_VERTEX_GENERATOR_MACROS_SVH
`define CYLINDER_VERTEX_GENERATOR_MACROS_SVH

// same-cycle implication
`define CVG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CVG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/cvg_pkg.sv @@
// ----------------------------------------------------------------------------
// cvg_pkg
// shared types, constants and fixed-point helpers of the cylinder vertex generator
// ----------------------------------------------------------------------------
package cvg_pkg;

    // geometry sizing
    localparam int RING_BITS  = 10;
    localparam int SLICE_BITS = 10;
    localparam int PHASE_BITS = 16;

    // phase bits below the PHASE_BITS resolution are dropped
    localparam int          PHASE_DROP = (PHASE_BITS >= 16) ? 0 : 16 - PHASE_BITS;
    localparam logic [15:0] PHASE_MASK = 16'hFFFF << PHASE_DROP;

    // slice number times turn step
    localparam int PROD_W = SLICE_BITS + 1 + 15;

    // register file
    localparam int REG_COUNT  = 5;
    localparam int APB_ADDR_W = $clog2(4 * REG_COUNT);

    typedef enum logic [2:0] {
        REG_CYL_RADIUS  = 3'd0,
        REG_HALF_LEN    = 3'd1,
        REG_RING_Y_STEP = 3'd2,
        REG_RING_V_STEP = 3'd3,
        REG_TURN_STEP   = 3'd4
    } reg_idx_t;

    localparam logic [30:0] CYL_RADIUS_RST  = 31'd65536;
    localparam logic [30:0] HALF_LEN_RST    = 31'd65536;
    localparam logic [30:0] RING_Y_STEP_RST = 31'd65536;
    localparam logic [15:0] RING_V_STEP_RST = 16'd32768;
    localparam logic [14:0] TURN_STEP_RST   = 15'd2048;

    typedef struct packed {
        logic [30:0] cyl_radius;
        logic [30:0] half_len;
        logic [30:0] ring_y_step;
        logic [15:0] ring_v_step;
        logic [14:0] turn_step;
    } cfg_t;

    // vertex kinds
    localparam logic [1:0] MODE_SIDE   = 2'd0;
    localparam logic [1:0] MODE_BOTTOM = 2'd1;

    // pipeline stages
    localparam int STG_IN       = 0;
    localparam int STG_PRE      = 1;
    localparam int STG_SC_FIRST = 2;
    localparam int STG_SC_LAST  = 7;
    localparam int STG_MUL      = 8;
    localparam int STG_OUT      = 9;
    localparam int STAGES       = 10;

    typedef logic [STAGES-1:0] stage_en_t;

    // quarter-wave sine polynomial, Q2.30 coefficients
    localparam logic [30:0] SC1 = 31'd1686629713;
    localparam logic [29:0] SC3 = 30'd693598668;
    localparam logic [26:0] SC5 = 27'd85569306;
    localparam logic [22:0] SC7 = 23'd5026995;
    localparam logic [17:0] SC9 = 18'd172272;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // texture and normal constants
    localparam logic [16:0] UV_ONE           = 17'd65536;
    localparam logic [16:0] UV_HALF          = 17'd32768;
    localparam logic [16:0] UV_QUARTER       = 17'd16384;
    localparam logic [16:0] UV_THREE_QUARTER = 17'd49152;
    localparam logic signed [15:0] NORM_POS_ONE = 16'sh7FFF;
    localparam logic signed [15:0] NORM_NEG_ONE = 16'sh8000;

    // per-stage sideband of a vertex
    typedef struct packed {
        logic [1:0]         mode;
        logic               center;
        logic [16:0]        u_side;
        logic [16:0]        v_side;
        logic signed [31:0] pos_y;
    } meta_t;

    // shift right, rounding half away from zero
    function automatic logic signed [31:0] rnd_shr32(input logic signed [31:0] v,
                                                     input int sh);
        logic signed [32:0] half;
        logic signed [32:0] t;
        half = 33'sd1 <<< (sh - 1);
        t    = 33'(v) + half - (v[31] ? 33'sd1 : 33'sd0);
        return 32'(t >>> sh);
    endfunction

    function automatic logic signed [63:0] rnd_shr64(input logic signed [63:0] v,
                                                     input int sh);
        logic signed [64:0] half;
        logic signed [64:0] t;
        half = 65'sd1 <<< (sh - 1);
        t    = 65'(v) + half - (v[63] ? 65'sd1 : 65'sd0);
        return 64'(t >>> sh);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        else
            return 32'(v);
    endfunction

    // Q2.30 to Q1.15 with +1 saturated
    function automatic logic signed [15:0] norm_q15(input logic signed [31:0] v);
        logic signed [31:0] n;
        n = rnd_shr32(v, 15);
        if (n > 32'sd32767)
            return NORM_POS_ONE;
        else if (n < -32'sd32768)
            return NORM_NEG_ONE;
        else
            return 16'(n);
    endfunction

endpackage

@@ hdl/cvg_regs.sv @@
// ----------------------------------------------------------------------------
// cvg_regs
// configuration registers behind the apb port
// ----------------------------------------------------------------------------
module cvg_regs
    import cvg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [30:0] cyl_radius_reg;
    logic [30:0] half_len_reg;
    logic [30:0] ring_y_step_reg;
    logic [15:0] ring_v_step_reg;
    logic [14:0] turn_step_reg;
    logic        wr_en;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyl_radius_reg  <= CYL_RADIUS_RST;
            half_len_reg    <= HALF_LEN_RST;
            ring_y_step_reg <= RING_Y_STEP_RST;
            ring_v_step_reg <= RING_V_STEP_RST;
            turn_step_reg   <= TURN_STEP_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_CYL_RADIUS:  cyl_radius_reg  <= pwdata[30:0];
                REG_HALF_LEN:    half_len_reg    <= pwdata[30:0];
                REG_RING_Y_STEP: ring_y_step_reg <= pwdata[30:0];
                REG_RING_V_STEP: ring_v_step_reg <= pwdata[15:0];
                REG_TURN_STEP:   turn_step_reg   <= pwdata[14:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_CYL_RADIUS:  prdata = 32'(cyl_radius_reg);
            REG_HALF_LEN:    prdata = 32'(half_len_reg);
            REG_RING_Y_STEP: prdata = 32'(ring_y_step_reg);
            REG_RING_V_STEP: prdata = 32'(ring_v_step_reg);
            REG_TURN_STEP:   prdata = 32'(turn_step_reg);
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg.cyl_radius  = cyl_radius_reg;
    assign cfg.half_len    = half_len_reg;
    assign cfg.ring_y_step = ring_y_step_reg;
    assign cfg.ring_v_step = ring_v_step_reg;
    assign cfg.turn_step   = turn_step_reg;

endmodule

@@ hdl/cvg_pipe_ctrl.sv @@
// ----------------------------------------------------------------------------
// cvg_pipe_ctrl
// stage valid bits and bubble-collapsing load enables of the vertex pipeline
// ----------------------------------------------------------------------------
`include "cylinder_vertex_generator_macros.svh"

module cvg_pipe_ctrl
    import cvg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output stage_en_t en
);

    stage_en_t valid_reg;
    stage_en_t valid_next;
    logic      in_fire;
    logic      out_fire;

    // a stage loads when it is empty or its word moves on
    always_comb
    begin
        en[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
    end

    always_comb
    begin
        valid_next[STG_IN] = en[STG_IN] ? in_valid : valid_reg[STG_IN];
        for (int k = 1; k < STAGES; k++)
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_ready  = en[STG_IN];
    assign out_valid = valid_reg[STAGES-1];
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    `CVG_ASSERT_IMP(a_blocked_only_when_full, !in_ready, &valid_reg, "input blocked with a bubble in the pipe")
    `CVG_ASSERT_IMP(a_ready_flows_back, out_ready, in_ready, "input stalled while output drains")
    `CVG_ASSERT_NXT(a_word_count, 1'b1, $countones(valid_reg) == $past($countones(valid_reg)) + int'($past(in_fire)) - int'($past(out_fire)), "word lost or duplicated in pipeline")

endmodule

@@ hdl/cvg_sincos.sv @@
// ----------------------------------------------------------------------------
// cvg_sincos
// pipelined sine and cosine of a turn phase, one horner step per stage
// ----------------------------------------------------------------------------
module cvg_sincos
    import cvg_pkg::*;
(
    input  logic               clk,
    input  stage_en_t          en,
    input  logic [15:0]        phase,
    output logic signed [31:0] sin_q30,
    output logic signed [31:0] cos_q30
);

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } quad_t;

    // lane 0 works on f, lane 1 on one minus f (both as f = m << 16)
    logic [14:0] m_next  [2];
    logic [28:0] m2_next [2];
    logic [22:0] h7_next [2];
    logic [26:0] h5_next [2];
    logic [29:0] h3_next [2];
    logic [30:0] h1_next [2];
    logic [30:0] qs      [2];
    logic [15:0] phase_m;

    logic [14:0] m_reg  [STG_SC_FIRST:STG_SC_LAST-1][2];
    logic [28:0] m2_reg [STG_SC_FIRST:STG_SC_LAST-2][2];
    quad_t       q_reg  [STG_SC_FIRST:STG_SC_LAST-1];
    logic [22:0] h7_reg [2];
    logic [26:0] h5_reg [2];
    logic [29:0] h3_reg [2];
    logic [30:0] h1_reg [2];

    logic signed [31:0] sa;
    logic signed [31:0] sb;
    logic signed [31:0] s_next;
    logic signed [31:0] c_next;
    logic signed [31:0] s_reg;
    logic signed [31:0] c_reg;

    assign phase_m = phase & PHASE_MASK;

    // x squared in Q30 is m squared shifted left by two
    always_comb
    begin
        m_next[0] = {1'b0, phase_m[13:0]};
        m_next[1] = 15'd16384 - {1'b0, phase_m[13:0]};
        for (int i = 0; i < 2; i++)
            m2_next[i] = 29'(30'(m_next[i]) * 30'(m_next[i]));
    end

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            h7_next[i] = 23'(47'(SC7) - ((47'(m2_reg[STG_SC_FIRST][i]) * 47'(SC9)) >> 28));
            h5_next[i] = 27'(52'(SC5) -
                             ((52'(m2_reg[STG_SC_FIRST+1][i]) * 52'(h7_reg[i])) >> 28));
            h3_next[i] = 30'(56'(SC3) -
                             ((56'(m2_reg[STG_SC_FIRST+2][i]) * 56'(h5_reg[i])) >> 28));
            h1_next[i] = 31'(59'(SC1) -
                             ((59'(m2_reg[STG_SC_FIRST+3][i]) * 59'(h3_reg[i])) >> 28));
        end
    end

    // last step times x, clamped to one
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (((46'(m_reg[STG_SC_LAST-1][i]) * 46'(h1_reg[i])) >> 14) > 46'(ONE_Q30))
                qs[i] = ONE_Q30;
            else
                qs[i] = 31'((46'(m_reg[STG_SC_LAST-1][i]) * 46'(h1_reg[i])) >> 14);
        end
        sa = $signed({1'b0, qs[0]});
        sb = $signed({1'b0, qs[1]});
        case (q_reg[STG_SC_LAST-1])
            QUAD_I:
            begin
                s_next = sa;
                c_next = sb;
            end
            QUAD_II:
            begin
                s_next = sb;
                c_next = -sa;
            end
            QUAD_III:
            begin
                s_next = -sa;
                c_next = -sb;
            end
            QUAD_IV:
            begin
                s_next = -sb;
                c_next = sa;
            end
            default:
            begin
                s_next = sa;
                c_next = sb;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[STG_SC_FIRST])
        begin
            m_reg[STG_SC_FIRST]  <= m_next;
            m2_reg[STG_SC_FIRST] <= m2_next;
            q_reg[STG_SC_FIRST]  <= quad_t'(phase_m[15:14]);
        end
        for (int k = STG_SC_FIRST + 1; k <= STG_SC_LAST - 1; k++)
        begin
            if (en[k])
            begin
                m_reg[k] <= m_reg[k-1];
                q_reg[k] <= q_reg[k-1];
            end
        end
        for (int k = STG_SC_FIRST + 1; k <= STG_SC_LAST - 2; k++)
        begin
            if (en[k])
                m2_reg[k] <= m2_reg[k-1];
        end
        if (en[STG_SC_FIRST+1])
            h7_reg <= h7_next;
        if (en[STG_SC_FIRST+2])
            h5_reg <= h5_next;
        if (en[STG_SC_FIRST+3])
            h3_reg <= h3_next;
        if (en[STG_SC_FIRST+4])
            h1_reg <= h1_next;
        if (en[STG_SC_LAST])
        begin
            s_reg <= s_next;
            c_reg <= c_next;
        end
    end

    assign sin_q30 = s_reg;
    assign cos_q30 = c_reg;

endmodule

@@ hdl/cylinder_vertex_generator.sv @@
// ----------------------------------------------------------------------------
// cylinder_vertex_generator
// position, texture coordinate and normal of one cylinder mesh vertex per word.
// input stream: tuser carries the vertex kind (side, bottom cap, top cap) and the
// cap center flag, tdata the ring and slice numbers. output stream: one result
// word per input word, in order, positions Q15.16, uv Q1.16, normals Q1.15.
// geometry (radius, half length, ring steps, turn step) is set over apb; the user
// must set it only while no vertex is in flight, the block leaves that to the user.
// throughput: one vertex per clock while the output is not stalled; the ten-stage
// pipe (input, steps, six sine/cosine polynomial stages, radius multiply, output)
// runs back to back.
// stall: an output stall freezes only the full stages; empty stages keep taking
// words until every stage holds one, then s_axis_tready drops.
// reset: empties the pipe and loads the default geometry (unit radius, unit half
// length, 32 slices).
// ----------------------------------------------------------------------------
module cylinder_vertex_generator
    import cvg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // slave stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,   // ring_idx[9:0], slice_idx[20:10]
    input  logic [2:0]            s_axis_tuser,   // mode[1:0], is_center[2]
    // master stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], tex_u[112:96], tex_v[129:113],
    // norm_x[145:130], norm_y[161:146], norm_z[177:162]
    output logic [183:0]          m_axis_tdata,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t      cfg;
    stage_en_t en;

    // input register
    logic [1:0]            mode_reg;
    logic                  center_reg;
    logic [RING_BITS-1:0]  ring_reg;
    logic [SLICE_BITS:0]   slice_reg;

    // step stage
    logic [PROD_W-1:0]            prod_next;
    logic [RING_BITS+15:0]        vprod;
    logic [RING_BITS+16:0]        vsum;
    logic [RING_BITS+30:0]        yprod;
    logic signed [RING_BITS+32:0] ysum;
    meta_t                        meta_next;
    logic [15:0]                  phase_reg;
    meta_t                        meta_reg [STG_PRE:STG_SC_LAST];

    // sine and cosine, Q2.30
    logic signed [31:0] sin_q30;
    logic signed [31:0] cos_q30;

    // radius multiply stage
    meta_t              meta_m;
    logic               is_side;
    logic               is_bottom;
    logic signed [31:0] radius_s;
    logic signed [31:0] cos_r16;
    logic signed [31:0] sin_r16;
    logic signed [17:0] u_rim;
    logic signed [17:0] v_rim;
    logic signed [63:0] rc_next;
    logic signed [63:0] rs_next;
    logic [16:0]        u_next;
    logic [16:0]        v_next;
    logic signed [15:0] nx_next;
    logic signed [15:0] ny_next;
    logic signed [15:0] nz_next;
    logic               zero_xz_next;

    logic signed [63:0] rc_reg;
    logic signed [63:0] rs_reg;
    logic [16:0]        u_reg;
    logic [16:0]        v_reg;
    logic signed [15:0] nx_reg;
    logic signed [15:0] ny_reg;
    logic signed [15:0] nz_reg;
    logic signed [31:0] py_reg;
    logic               zero_xz_reg;

    // output register
    logic signed [31:0] pos_x_reg;
    logic signed [31:0] pos_y_reg;
    logic signed [31:0] pos_z_reg;
    logic [16:0]        tex_u_reg;
    logic [16:0]        tex_v_reg;
    logic signed [15:0] norm_x_reg;
    logic signed [15:0] norm_y_reg;
    logic signed [15:0] norm_z_reg;

    cvg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cvg_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .en        (en)
    );

    // input register
    always_ff @(posedge clk)
    begin
        if (en[STG_IN])
        begin
            mode_reg   <= s_axis_tuser[1:0];
            center_reg <= s_axis_tuser[2];
            ring_reg   <= RING_BITS'(s_axis_tdata[9:0]);
            slice_reg  <= (SLICE_BITS+1)'(s_axis_tdata[20:10]);
        end
    end

    // slice phase, side uv and axial position
    always_comb
    begin
        prod_next = PROD_W'(slice_reg) * PROD_W'(cfg.turn_step);
        vprod     = (RING_BITS+16)'(ring_reg) * (RING_BITS+16)'(cfg.ring_v_step);
        vsum      = (RING_BITS+17)'(UV_HALF) + (RING_BITS+17)'(vprod);
        yprod     = (RING_BITS+31)'(ring_reg) * (RING_BITS+31)'(cfg.ring_y_step);
        ysum      = $signed((RING_BITS+33)'(yprod)) - $signed((RING_BITS+33)'(cfg.half_len));

        meta_next.mode   = mode_reg;
        meta_next.center = center_reg;
        // u saturates at one full turn, v at the top edge
        meta_next.u_side = (prod_next > PROD_W'(UV_ONE)) ? UV_ONE : prod_next[16:0];
        meta_next.v_side = (vsum > (RING_BITS+17)'(UV_ONE)) ? UV_ONE : vsum[16:0];
        if (mode_reg == MODE_SIDE)
            meta_next.pos_y = sat32(64'(ysum));
        else if (mode_reg == MODE_BOTTOM)
            meta_next.pos_y = -$signed({1'b0, cfg.half_len});
        else
            meta_next.pos_y = $signed({1'b0, cfg.half_len});
    end

    // sideband delay line alongside the sine/cosine stages
    always_ff @(posedge clk)
    begin
        if (en[STG_PRE])
        begin
            meta_reg[STG_PRE] <= meta_next;
            phase_reg         <= prod_next[15:0];
        end
        for (int k = STG_PRE + 1; k <= STG_SC_LAST; k++)
        begin
            if (en[k])
                meta_reg[k] <= meta_reg[k-1];
        end
    end

    cvg_sincos u_sincos (
        .clk     (clk),
        .en      (en),
        .phase   (phase_reg),
        .sin_q30 (sin_q30),
        .cos_q30 (cos_q30)
    );

    // radius products, normals and final uv
    always_comb
    begin
        meta_m    = meta_reg[STG_SC_LAST];
        is_side   = (meta_m.mode == MODE_SIDE);
        is_bottom = (meta_m.mode == MODE_BOTTOM);
        radius_s  = $signed({1'b0, cfg.cyl_radius});
        rc_next   = radius_s * cos_q30;
        rs_next   = radius_s * sin_q30;
        cos_r16   = rnd_shr32(cos_q30, 16);
        sin_r16   = rnd_shr32(sin_q30, 16);

        // rim uv: quarter-size circle around the cap's texture center
        u_rim = $signed({1'b0, (is_bottom ? UV_THREE_QUARTER : UV_QUARTER)}) + 18'(cos_r16);
        if (is_bottom)
            v_rim = $signed({1'b0, UV_QUARTER}) + 18'(sin_r16);
        else
            v_rim = $signed({1'b0, UV_QUARTER}) - 18'(sin_r16);

        if (is_side)
        begin
            u_next  = meta_m.u_side;
            v_next  = meta_m.v_side;
            nx_next = norm_q15(cos_q30);
            ny_next = 16'sd0;
            nz_next = norm_q15(sin_q30);
        end
        else
        begin
            nx_next = 16'sd0;
            ny_next = is_bottom ? NORM_NEG_ONE : NORM_POS_ONE;
            nz_next = 16'sd0;
            if (meta_m.center)
            begin
                u_next = is_bottom ? UV_THREE_QUARTER : UV_QUARTER;
                v_next = UV_QUARTER;
            end
            else
            begin
                u_next = 17'(u_rim);
                v_next = 17'(v_rim);
            end
        end
        // cap center sits on the axis
        zero_xz_next = !is_side && meta_m.center;
    end

    always_ff @(posedge clk)
    begin
        if (en[STG_MUL])
        begin
            rc_reg      <= rc_next;
            rs_reg      <= rs_next;
            u_reg       <= u_next;
            v_reg       <= v_next;
            nx_reg      <= nx_next;
            ny_reg      <= ny_next;
            nz_reg      <= nz_next;
            py_reg      <= meta_m.pos_y;
            zero_xz_reg <= zero_xz_next;
        end
    end

    // output register: round Q30 products back to Q15.16 and saturate
    always_ff @(posedge clk)
    begin
        if (en[STG_OUT])
        begin
            pos_x_reg  <= zero_xz_reg ? 32'sd0 : sat32(rnd_shr64(rc_reg, 30));
            pos_z_reg  <= zero_xz_reg ? 32'sd0 : sat32(rnd_shr64(rs_reg, 30));
            pos_y_reg  <= py_reg;
            tex_u_reg  <= u_reg;
            tex_v_reg  <= v_reg;
            norm_x_reg <= nx_reg;
            norm_y_reg <= ny_reg;
            norm_z_reg <= nz_reg;
        end
    end

    assign m_axis_tdata = {6'd0, norm_z_reg, norm_y_reg, norm_x_reg, tex_v_reg, tex_u_reg,
                           pos_z_reg, pos_y_reg, pos_x_reg};

endmodule

@@ bench/cvg_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cylinder vertex generator bench package
// vertex request and attribute types, and a scoreboard that predicts the
// position, uv and normal of every accepted vertex and checks result words
// ----------------------------------------------------------------------------
package cvg_tb_pkg;
    import cvg_pkg::*;

    localparam logic [1:0] MODE_TOP       = 2'd2;
    // the unused kind code decodes as a top cap
    localparam logic [1:0] MODE_TOP_ALIAS = 2'd3;

    // quarter-wave sine polynomial, Q2.30
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint POLY_K1 = 64'sd1686629713;
    localparam longint POLY_K3 = 64'sd693598668;
    localparam longint POLY_K5 = 64'sd85569306;
    localparam longint POLY_K7 = 64'sd5026995;
    localparam longint POLY_K9 = 64'sd172272;

    // uv anchors, Q1.16
    localparam longint TEX_ONE     = 64'sd65536;
    localparam longint TEX_HALF    = 64'sd32768;
    localparam longint TEX_QUARTER = 64'sd16384;
    localparam longint TEX_3QUART  = 64'sd49152;

    typedef struct packed {
        logic [1:0]  mode;
        logic        center;
        logic [9:0]  ring;
        logic [10:0] slice;
    } vertex_req_t;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic [15:0] norm_x;
        logic [15:0] norm_y;
        logic [15:0] norm_z;
    } vertex_attr_t;

    class vertex_scoreboard;
        // geometry as currently programmed
        logic [30:0] radius;
        logic [30:0] half_length;
        logic [30:0] y_step;
        logic [15:0] v_step;
        logic [14:0] phase_step;

        vertex_attr_t expected_q[$];
        int unsigned  mismatches;

        function new();
            radius      = 31'd65536;
            half_length = 31'd65536;
            y_step      = 31'd65536;
            v_step      = 16'd32768;
            phase_step  = 15'd2048;
            mismatches  = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_CYL_RADIUS:  radius      = value[30:0];
                REG_HALF_LEN:    half_length = value[30:0];
                REG_RING_Y_STEP: y_step      = value[30:0];
                REG_RING_V_STEP: v_step      = value[15:0];
                REG_TURN_STEP:   phase_step  = value[14:0];
                default: ;
            endcase
        endfunction

        // shift right, rounding half away from zero
        function longint round_shr(longint value, int sh);
            longint mag;
            mag = (value < 0) ? -value : value;
            mag = (mag + (longint'(1) <<< (sh - 1))) >>> sh;
            return (value < 0) ? -mag : mag;
        endfunction

        function longint clamp32(longint value);
            if (value > 64'sd2147483647)
                return 64'sd2147483647;
            if (value < -64'sd2147483648)
                return -64'sd2147483648;
            return value;
        endfunction

        function longint to_q15(longint value);
            longint n;
            n = round_shr(value, 15);
            if (n > 64'sd32767)
                n = 64'sd32767;
            if (n < -64'sd32768)
                n = -64'sd32768;
            return n;
        endfunction

        // sin(x * pi/2) for x in [0, 1], Q30 in and out, capped at one
        function longint quarter_wave(longint x);
            longint x2;
            longint acc;
            x2  = (x * x) >>> 30;
            acc = POLY_K9;
            acc = POLY_K7 - ((x2 * acc) >>> 30);
            acc = POLY_K5 - ((x2 * acc) >>> 30);
            acc = POLY_K3 - ((x2 * acc) >>> 30);
            acc = POLY_K1 - ((x2 * acc) >>> 30);
            acc = (x * acc) >>> 30;
            return (acc > Q30_ONE) ? Q30_ONE : acc;
        endfunction

        function void sine_cosine(logic [15:0] phase, output longint s, output longint c);
            logic [31:0] t;
            longint      f;
            longint      a;
            longint      b;
            t = {phase, 16'h0000};
            t = t & ~((32'h1 << (32 - PHASE_BITS)) - 32'h1);
            f = longint'(t[29:0]);
            a = quarter_wave(f);
            b = quarter_wave(Q30_ONE - f);
            // quadrant from the top two phase bits
            case (t[31:30])
                2'd0:
                begin
                    s = a;
                    c = b;
                end
                2'd1:
                begin
                    s = b;
                    c = -a;
                end
                2'd2:
                begin
                    s = -a;
                    c = -b;
                end
                default:
                begin
                    s = -b;
                    c = a;
                end
            endcase
        endfunction

        function vertex_attr_t compute_vertex(vertex_req_t req);
            vertex_attr_t e;
            logic [31:0]  prod;
            logic         bottom;
            longint       s, c, r, px, py, pz, u, v, nx, ny, nz;
            prod = 32'(req.slice) * 32'(phase_step);
            sine_cosine(prod[15:0], s, c);
            r      = longint'(radius);
            bottom = (req.mode == MODE_BOTTOM);
            if (req.mode == MODE_SIDE)
            begin
                px = round_shr(r * c, 30);
                pz = round_shr(r * s, 30);
                py = clamp32(longint'(req.ring) * longint'(y_step) - longint'(half_length));
                u  = (prod > 32'd65536) ? TEX_ONE : longint'(prod);
                v  = TEX_HALF + longint'(req.ring) * longint'(v_step);
                if (v > TEX_ONE)
                    v = TEX_ONE;
                nx = to_q15(c);
                ny = 0;
                nz = to_q15(s);
            end
            else
            begin
                py = bottom ? -longint'(half_length) : longint'(half_length);
                nx = 0;
                nz = 0;
                ny = bottom ? -64'sd32768 : 64'sd32767;
                if (req.center)
                begin
                    px = 0;
                    pz = 0;
                    u  = bottom ? TEX_3QUART : TEX_QUARTER;
                    v  = TEX_QUARTER;
                end
                else
                begin
                    px = round_shr(r * c, 30);
                    pz = round_shr(r * s, 30);
                    u  = (bottom ? TEX_3QUART : TEX_QUARTER) + round_shr(c, 16);
                    v  = bottom ? TEX_QUARTER + round_shr(s, 16)
                                : TEX_QUARTER - round_shr(s, 16);
                end
            end
            e.pos_x  = 32'(clamp32(px));
            e.pos_y  = 32'(py);
            e.pos_z  = 32'(clamp32(pz));
            e.tex_u  = 17'(u);
            e.tex_v  = 17'(v);
            e.norm_x = 16'(nx);
            e.norm_y = 16'(ny);
            e.norm_z = 16'(nz);
            return e;
        endfunction

        // accepted input word: kind in tuser, ring and slice in tdata
        function void note_vertex(logic [2:0] kind, logic [23:0] data);
            vertex_req_t req;
            req.mode   = kind[1:0];
            req.center = kind[2];
            req.ring   = data[9:0];
            req.slice  = data[20:10];
            expected_q.push_back(compute_vertex(req));
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, name, want, got);
            end
        endfunction

        function void check_vertex(logic [183:0] word);
            vertex_attr_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result word with no vertex pending, expected none, actual %h",
                         $time, word);
                return;
            end
            e = expected_q.pop_front();
            compare_field("pos_x",  e.pos_x,  word[31:0]);
            compare_field("pos_y",  e.pos_y,  word[63:32]);
            compare_field("pos_z",  e.pos_z,  word[95:64]);
            compare_field("tex_u",  e.tex_u,  word[112:96]);
            compare_field("tex_v",  e.tex_v,  word[129:113]);
            compare_field("norm_x", e.norm_x, word[145:130]);
            compare_field("norm_y", e.norm_y, word[161:146]);
            compare_field("norm_z", e.norm_z, word[177:162]);
        endfunction

        function int unsigned vertices_in_flight();
            return expected_q.size();
        endfunction

        function int unsigned mismatch_total();
            return mismatches;
        endfunction
    endclass

endpackage

@@ bench/cylinder_vertex_generator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cylinder_vertex_generator_tb
// drives vertex requests (side, bottom cap, top cap, centers and rims) through
// the stream input under several geometries set over apb, and checks every
// result word field by field against a fixed-point model of the generator.
// the sender runs in random bursts, the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module cylinder_vertex_generator_tb;
    import cvg_pkg::*;
    import cvg_tb_pkg::*;

    // pipe is 10 deep, give it some slack before touching the registers
    localparam int     DRAIN_CYCLES = 16;
    localparam int     PHASE_ITEMS  = 150;
    localparam longint WATCHDOG_NS  = 3_000_000;

    // receiver stall patterns
    localparam int RX_OPEN    = 0;
    localparam int RX_COIN    = 1;
    localparam int RX_SPARSE  = 2;
    localparam int RX_PATTERN = 3;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata  = '0;
    logic [2:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [183:0]          m_axis_tdata;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [31:0]           pwdata        = '0;
    logic [31:0]           prdata;
    logic                  pready;

    vertex_scoreboard sb = new();

    // words left in the current sender burst
    int unsigned burst_left = 0;

    // receiver pattern state
    int unsigned rx_mode    = RX_OPEN;
    int unsigned rx_hold    = 64;
    logic [7:0]  rx_pattern = 8'hA5;

    cylinder_vertex_generator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // input monitor: the word is predicted with the geometry in force
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_vertex(s_axis_tuser, s_axis_tdata);
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_vertex(m_axis_tdata);
    end

    // receiver: switches between always ready, coin toss, mostly stalled
    // and a rotating 8-bit pattern whenever its random hold count runs out
    always @(posedge clk)
    begin
        if (rx_hold == 0)
        begin
            rx_mode    <= $urandom_range(RX_OPEN, RX_PATTERN);
            rx_hold    <= $urandom_range(32, 256);
            rx_pattern <= 8'($urandom);
        end
        else
            rx_hold <= rx_hold - 1;
        case (rx_mode)
            RX_COIN:    m_axis_tready <= 1'($urandom);
            RX_SPARSE:  m_axis_tready <= ($urandom_range(0, 3) == 0);
            RX_PATTERN: m_axis_tready <= rx_pattern[rx_hold[2:0]];
            default:    m_axis_tready <= 1'b1;
        endcase
    end

    // apb write: setup cycle, then access cycle until pready
    // the bus stays selected afterward, apb_idle releases it
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    // bus back to idle after a run of writes
    task automatic apb_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_geometry(input logic [30:0] radius, input logic [30:0] half_length,
                                  input logic [30:0] y_step, input logic [15:0] v_step,
                                  input logic [14:0] phase_step);
        write_reg(REG_CYL_RADIUS,  32'(radius));
        write_reg(REG_HALF_LEN,    32'(half_length));
        write_reg(REG_RING_Y_STEP, 32'(y_step));
        write_reg(REG_RING_V_STEP, 32'(v_step));
        write_reg(REG_TURN_STEP,   32'(phase_step));
        apb_idle();
    endtask

    // one input word; a new burst starts after a random gap, often none
    task automatic send_vertex(input vertex_req_t req);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, req.slice, req.ring};
        s_axis_tuser  <= {req.center, req.mode};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // hold the sender until every pending vertex is out, then let the pipe settle;
    // the first check follows a clock edge so the last accepted word is already in the scoreboard
    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.vertices_in_flight() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly mesh-shaped indices within the geometry, some whole-range noise
    function automatic vertex_req_t random_vertex(input int rings, input int slices);
        vertex_req_t req;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            req.mode = MODE_SIDE;
        else if (pick < 8)
            req.mode = MODE_BOTTOM;
        else if (pick < 9)
            req.mode = MODE_TOP;
        else
            req.mode = MODE_TOP_ALIAS;
        // center flag is a don't care on sides, so toss it freely there
        req.center = (req.mode == MODE_SIDE) ? 1'($urandom) : ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 4) == 0)
        begin
            if ($urandom_range(0, 3) == 0)
                req.ring = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
            else
                req.ring = 10'($urandom);
            if ($urandom_range(0, 3) == 0)
                req.slice = $urandom_range(0, 1) ? 11'd1024 : 11'd0;
            else
                req.slice = 11'($urandom_range(0, 1024));
        end
        else
        begin
            req.ring  = 10'($urandom_range(0, rings - 1));
            req.slice = 11'($urandom_range(0, slices));
        end
        return req;
    endfunction

    // random stretch with one full pause half way
    task automatic run_phase(input int rings, input int slices);
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (i == PHASE_ITEMS / 2)
                drain_pipe();
            send_vertex(random_vertex(rings, slices));
        end
        drain_pipe();
    endtask

    initial
    begin
        vertex_req_t directed[$];
        int          rings;
        int          slices;
        logic [30:0] radius;
        logic [30:0] half_length;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: 32 slices, quadrant boundaries at multiples of 8
        directed.push_back('{MODE_SIDE,      1'b0, 10'd0,    11'd0});
        directed.push_back('{MODE_SIDE,      1'b0, 10'd1023, 11'd1024});  // u and v clip
        directed.push_back('{MODE_SIDE,      1'b0, 10'h2AA,  11'h555});
        directed.push_back('{MODE_SIDE,      1'b1, 10'h155,  11'h2AA});   // flag ignored
        directed.push_back('{MODE_SIDE,      1'b0, 10'd0,    11'd8});
        directed.push_back('{MODE_SIDE,      1'b0, 10'd0,    11'd16});
        directed.push_back('{MODE_SIDE,      1'b0, 10'd0,    11'd24});
        directed.push_back('{MODE_SIDE,      1'b0, 10'd0,    11'd32});    // u exactly one
        directed.push_back('{MODE_SIDE,      1'b0, 10'd0,    11'd33});    // u clips
        directed.push_back('{MODE_SIDE,      1'b0, 10'd512,  11'd1});
        directed.push_back('{MODE_SIDE,      1'b0, 10'd1023, 11'd0});
        directed.push_back('{MODE_BOTTOM,    1'b1, 10'd0,    11'd0});
        directed.push_back('{MODE_BOTTOM,    1'b1, 10'd1023, 11'd1024});  // indices ignored
        directed.push_back('{MODE_BOTTOM,    1'b0, 10'd0,    11'd0});
        directed.push_back('{MODE_BOTTOM,    1'b0, 10'd0,    11'd8});
        directed.push_back('{MODE_BOTTOM,    1'b0, 10'd0,    11'd16});
        directed.push_back('{MODE_BOTTOM,    1'b0, 10'd0,    11'd24});
        directed.push_back('{MODE_TOP,       1'b1, 10'd0,    11'd0});
        directed.push_back('{MODE_TOP,       1'b0, 10'd0,    11'd0});
        directed.push_back('{MODE_TOP,       1'b0, 10'd0,    11'd8});
        directed.push_back('{MODE_TOP,       1'b0, 10'd7,    11'd20});
        directed.push_back('{MODE_TOP_ALIAS, 1'b1, 10'd0,    11'd0});
        directed.push_back('{MODE_TOP_ALIAS, 1'b0, 10'd0,    11'd5});
        directed.push_back('{MODE_TOP_ALIAS, 1'b0, 10'd1023, 11'd1024});
        foreach (directed[i])
            send_vertex(directed[i]);
        drain_pipe();
        run_phase(1024, 32);

        // radius, half length and ring y step at their ceiling: axial positions and uv saturate
        apply_geometry(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'd32768, 15'd21845);
        run_phase(1024, 1024);

        // everything zero, including the turn step
        apply_geometry('0, '0, '0, '0, '0);
        run_phase(1024, 1024);

        // finest turn step with scattered sizes
        apply_geometry(31'($urandom), 31'($urandom), 31'($urandom),
                       16'($urandom_range(0, 32768)), 15'd1);
        run_phase(1024, 1024);

        // meshes as software would set them up, magnitudes spread out
        repeat (5)
        begin
            slices      = $urandom_range(3, 1024);
            rings       = $urandom_range(2, 1024);
            radius      = 31'($urandom) >> $urandom_range(0, 30);
            half_length = 31'($urandom) >> $urandom_range(1, 30);
            apply_geometry(radius, half_length,
                           31'((64'(half_length) * 2) / (rings - 1)),
                           16'(32768 / (rings - 1)),
                           15'(65536 / slices));
            run_phase(rings, slices);
        end

        drain_pipe();
        if (sb.mismatch_total() == 0 && sb.vertices_in_flight() == 0)
            $display("cylinder_vertex_generator verification clean");
        else
            $display("cylinder_vertex_generator verification failed");
        $finish;
    end

    // hang guard
    initial
    begin
        #(WATCHDOG_NS);
        $display("cylinder_vertex_generator verification failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/cvg_pkg.sv
hdl/cvg_regs.sv
hdl/cvg_pipe_ctrl.sv
hdl/cvg_sincos.sv
hdl/cylinder_vertex_generator.sv
bench/cvg_tb_pkg.sv
bench/cylinder_vertex_generator_tb.sv
